>>> hdl/cpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants and types for the causal pdf/cdf convolution block.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_SETTLE,
    ST_EMIT
  } cpc_state_t;

  // Sequencer to multiply-accumulate unit.
  typedef struct packed {
    logic clear;   // zero both accumulators
    logic valid;   // read data from the point store is a live pair
  } cpc_mac_ctrl_t;

endpackage : cpc_pkg
`default_nettype wire

>>> hdl/truncated_pdf_cdf_convolution_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// truncated_pdf_cdf_convolution_top
// A point with index t is accepted, then its t+1 multiply-accumulate pairs
// come out of the point store one per cycle; the sums drain, are rounded and
// emitted. A new point is accepted only after the result has been emitted.
// Reset clears the point index, previous cdf and handshakes; tolerance -> 1 LSB.
// The point store is not cleared: only entries of the current sequence are read.
// ----------------------------------------------------------------------------
module truncated_pdf_cdf_convolution_top #(
  parameter int MAX_POINTS = cpc_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = cpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FRAC_BITS:0] one_tolerance,
  // input points
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FRAC_BITS:0] own_pdf,
  input  wire logic [FRAC_BITS:0] own_cdf,
  input  wire logic [FRAC_BITS:0] other_pdf,
  input  wire logic               last_point,
  // results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [FRAC_BITS:0] out_pdf,
  output logic      [FRAC_BITS:0] out_cdf,
  output logic                    out_last,
  output logic                    completed
);

  localparam int VAL_W = FRAC_BITS + 1;
  localparam int ACC_W = 2 * FRAC_BITS + 1;
  localparam int RND_W = ACC_W + 1;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [VAL_W-1:0] ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);
  localparam logic [RND_W-1:0] HALF     = RND_W'(1) << (FRAC_BITS - 1);

  cpc_pkg::cpc_state_t    state, state_next;
  cpc_pkg::cpc_mac_ctrl_t mac_ctrl;

  logic [VAL_W-1:0] tolerance;
  logic [IDX_W-1:0] point_index;
  logic [IDX_W-1:0] tau;
  logic             last_r;
  logic             rd_valid;
  logic [VAL_W-1:0] previous_out_cdf;
  logic [VAL_W-1:0] pdf_s;
  logic [VAL_W-1:0] cdf_s;

  logic             accept;
  logic             issue;
  logic             issue_done;
  logic             settle_en;
  logic             emit;

  logic [VAL_W-1:0] sat_own_pdf;
  logic [VAL_W-1:0] sat_own_cdf;
  logic [VAL_W-1:0] sat_other_pdf;
  logic [VAL_W-1:0] rd_own_pdf;
  logic [VAL_W-1:0] rd_own_cdf;
  logic [VAL_W-1:0] rd_other_pdf;
  logic [ACC_W-1:0] acc_pdf;
  logic [ACC_W-1:0] acc_cdf;
  logic             mac_busy;

  logic [RND_W-1:0]        rnd_pdf;
  logic [RND_W-1:0]        rnd_cdf;
  logic [RND_W-FRAC_BITS-1:0] sh_pdf;
  logic [RND_W-FRAC_BITS-1:0] sh_cdf;
  logic [VAL_W-1:0]        cdf_gap;
  logic                    force_one;
  logic [VAL_W-1:0]        fin_pdf;
  logic [VAL_W-1:0]        fin_cdf;

  // clamp probabilities above 1.0
  always_comb begin
    sat_own_pdf   = (own_pdf   > ONE) ? ONE : own_pdf;
    sat_own_cdf   = (own_cdf   > ONE) ? ONE : own_cdf;
    sat_other_pdf = (other_pdf > ONE) ? ONE : other_pdf;
  end

  cpc_store #(
    .MAX_POINTS (MAX_POINTS),
    .VAL_W      (VAL_W)
  ) u_store (
    .clk           (clk),
    .wr_en         (accept),
    .wr_addr       (point_index),
    .wr_own_pdf    (sat_own_pdf),
    .wr_own_cdf    (sat_own_cdf),
    .wr_other_pdf  (sat_other_pdf),
    .rd_own_addr   (tau),
    .rd_other_addr (point_index - tau),
    .rd_own_pdf    (rd_own_pdf),
    .rd_own_cdf    (rd_own_cdf),
    .rd_other_pdf  (rd_other_pdf)
  );

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.valid = rd_valid;

  cpc_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .own_pdf   (rd_own_pdf),
    .own_cdf   (rd_own_cdf),
    .other_pdf (rd_other_pdf),
    .acc_pdf   (acc_pdf),
    .acc_cdf   (acc_cdf),
    .busy      (mac_busy)
  );

  // round half up; the clamp at 1.0 follows in ST_SETTLE
  always_comb begin
    rnd_pdf = RND_W'(acc_pdf) + HALF;
    rnd_cdf = RND_W'(acc_cdf) + HALF;
    sh_pdf  = rnd_pdf[RND_W-1:FRAC_BITS];
    sh_cdf  = rnd_cdf[RND_W-1:FRAC_BITS];
  end

  // complete the final cdf to 1.0 when it falls short of 1.0 by more than tolerance
  always_comb begin
    cdf_gap   = ONE - cdf_s;
    force_one = last_r && (cdf_gap > tolerance);
    fin_cdf   = force_one ? ONE : cdf_s;
    if (force_one) begin
      fin_pdf = (previous_out_cdf >= ONE) ? '0 : ONE - previous_out_cdf;
    end else begin
      fin_pdf = pdf_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    issue      = 1'b0;
    issue_done = 1'b0;
    settle_en  = 1'b0;
    emit       = 1'b0;
    in_ready   = 1'b0;
    case (state)
      cpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept     = 1'b1;
          state_next = cpc_pkg::ST_ISSUE;
        end
      end
      cpc_pkg::ST_ISSUE: begin
        issue = 1'b1;
        if (tau == point_index) begin
          issue_done = 1'b1;
          state_next = cpc_pkg::ST_DRAIN;
        end
      end
      cpc_pkg::ST_DRAIN: begin
        if (!rd_valid && !mac_busy) begin
          state_next = cpc_pkg::ST_SETTLE;
        end
      end
      cpc_pkg::ST_SETTLE: begin
        settle_en  = 1'b1;
        state_next = cpc_pkg::ST_EMIT;
      end
      cpc_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = cpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cpc_pkg::ST_IDLE;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance        <= VAL_W'(1);
      point_index      <= '0;
      previous_out_cdf <= '0;
      rd_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tolerance <= one_tolerance;
      end
      rd_valid <= issue;
      if (emit) begin
        out_valid <= 1'b1;
        if (last_r) begin
          point_index      <= '0;
          previous_out_cdf <= '0;
        end else begin
          point_index      <= point_index + IDX_W'(1);
          previous_out_cdf <= fin_cdf;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last_point || (point_index == LAST_IDX);
      tau    <= '0;
    end else if (issue && !issue_done) begin
      tau <= tau + IDX_W'(1);
    end
    if (settle_en) begin
      pdf_s <= (sh_pdf > (RND_W-FRAC_BITS)'(ONE)) ? ONE : sh_pdf[VAL_W-1:0];
      cdf_s <= (sh_cdf > (RND_W-FRAC_BITS)'(ONE)) ? ONE : sh_cdf[VAL_W-1:0];
    end
    if (emit) begin
      out_pdf   <= fin_pdf;
      out_cdf   <= fin_cdf;
      out_last  <= last_r;
      completed <= force_one;
    end
  end

endmodule : truncated_pdf_cdf_convolution_top
`default_nettype wire

>>> hdl/cpc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_store
// Point store: own pdf/cdf memory read at tau, other pdf memory read at t-tau.
// One write port, one registered read port per memory.
// ----------------------------------------------------------------------------
module cpc_store #(
  parameter int MAX_POINTS = cpc_pkg::MAX_POINTS_DEF,
  parameter int VAL_W      = cpc_pkg::FRAC_BITS_DEF + 1
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  input  wire logic [VAL_W-1:0]              wr_own_pdf,
  input  wire logic [VAL_W-1:0]              wr_own_cdf,
  input  wire logic [VAL_W-1:0]              wr_other_pdf,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_own_addr,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_other_addr,
  output logic      [VAL_W-1:0]              rd_own_pdf,
  output logic      [VAL_W-1:0]              rd_own_cdf,
  output logic      [VAL_W-1:0]              rd_other_pdf
);

  logic [2*VAL_W-1:0] own_mem   [MAX_POINTS];
  logic [VAL_W-1:0]   other_mem [MAX_POINTS];
  logic [2*VAL_W-1:0] own_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      own_mem[wr_addr]   <= {wr_own_pdf, wr_own_cdf};
      other_mem[wr_addr] <= wr_other_pdf;
    end
    own_rd       <= own_mem[rd_own_addr];
    rd_other_pdf <= other_mem[rd_other_addr];
  end

  assign rd_own_pdf = own_rd[2*VAL_W-1:VAL_W];
  assign rd_own_cdf = own_rd[VAL_W-1:0];

endmodule : cpc_store
`default_nettype wire

>>> hdl/cpc_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_mac
// Two-lane multiply-accumulate: registered products, then saturating sums
// capped at 1.0 in the product scale.
// ----------------------------------------------------------------------------
module cpc_mac #(
  parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cpc_pkg::cpc_mac_ctrl_t      ctrl,
  input  wire logic [FRAC_BITS:0]          own_pdf,
  input  wire logic [FRAC_BITS:0]          own_cdf,
  input  wire logic [FRAC_BITS:0]          other_pdf,
  output logic      [2*FRAC_BITS:0]        acc_pdf,
  output logic      [2*FRAC_BITS:0]        acc_cdf,
  output logic                             busy
);

  localparam int VAL_W  = FRAC_BITS + 1;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 2 * FRAC_BITS + 1;
  localparam logic [PROD_W-1:0] CAP = {{(PROD_W-ACC_W){1'b0}}, 1'b1, {(2*FRAC_BITS){1'b0}}};

  logic              prod_valid;
  logic [PROD_W-1:0] prod_pdf;
  logic [PROD_W-1:0] prod_cdf;
  logic [PROD_W-1:0] sum_pdf;
  logic [PROD_W-1:0] sum_cdf;

  always_comb begin
    sum_pdf = PROD_W'(acc_pdf) + prod_pdf;
    sum_cdf = PROD_W'(acc_cdf) + prod_cdf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_pdf <= PROD_W'(own_pdf) * PROD_W'(other_pdf);
    prod_cdf <= PROD_W'(own_cdf) * PROD_W'(other_pdf);
    if (ctrl.clear) begin
      acc_pdf <= '0;
      acc_cdf <= '0;
    end else if (prod_valid) begin
      // clamp at 1.0 after every addition
      acc_pdf <= (sum_pdf > CAP) ? CAP[ACC_W-1:0] : sum_pdf[ACC_W-1:0];
      acc_cdf <= (sum_cdf > CAP) ? CAP[ACC_W-1:0] : sum_cdf[ACC_W-1:0];
    end
  end

  assign busy = prod_valid;

endmodule : cpc_mac
`default_nettype wire
